// ----- src/sepq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sepq_pkg
// Shared types and codes for the sorted event priority queue.
// ----------------------------------------------------------------------------
package sepq_pkg;

  localparam logic [1:0] CMD_INSERT     = 2'd0;
  localparam logic [1:0] CMD_REMOVE_MIN = 2'd1;
  localparam logic [1:0] CMD_REMOVE_CUS = 2'd2;

  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_FULL      = 2'd1;
  localparam logic [1:0] STAT_EMPTY     = 2'd2;
  localparam logic [1:0] STAT_NOT_FOUND = 2'd3;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] event_time;
    logic [15:0] event_id;
    logic [15:0] customer_id;
  } req_t;

  typedef struct packed {
    logic [15:0] out_event_id;
    logic [31:0] out_event_time;
    logic [1:0]  status;
    logic [7:0]  occupancy;
  } rsp_t;

  typedef struct packed {
    logic [31:0] ev_time;
    logic [15:0] ev_id;
    logic [15:0] cust;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // controller to datapath
  typedef struct packed {
    logic       load_req;
    logic       scan_start;
    logic       scan_adv;
    logic       hit;
    logic       move_rd;
    logic       move_wr;
    logic       put_wr;
    logic       set_status;
    logic [1:0] status_val;
    logic       cnt_inc;
    logic       cnt_dec;
    logic       out_load;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] new_cmd;
    logic [1:0] cur_cmd;
    logic       full;
    logic       empty;
    logic       scan_end;
    logic       match;
    logic       move_done;
    logic       out_busy;
  } dp_stat_t;

endpackage

// ----- src/sepq_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sepq_ram
// Generic single write, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module sepq_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/sepq_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sepq_datapath
// Request and result registers, entry count, scan and move pointers, and the
// entry store.
// ----------------------------------------------------------------------------
module sepq_datapath #(
  parameter int QUEUE_DEPTH = 128
) (
  input  logic              clk,
  input  logic              rst,
  input  sepq_pkg::req_t    req,
  input  logic              rsp_stall,
  output logic              rsp_valid,
  output sepq_pkg::rsp_t    rsp,
  input  sepq_pkg::dp_cmd_t cmd,
  output sepq_pkg::dp_stat_t stat
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  sepq_pkg::req_t   req_q;
  logic [CW-1:0]    count;
  logic [CW-1:0]    idx;
  logic [CW-1:0]    mv;
  logic [15:0]      res_id;
  logic [31:0]      res_time;
  logic [1:0]       res_status;

  logic [CW-1:0]    mv_inc;
  logic [CW-1:0]    mv_dec;
  logic             is_insert;
  logic             we;
  logic [AW-1:0]    waddr;
  logic [AW-1:0]    raddr;
  sepq_pkg::entry_t wdata;
  sepq_pkg::entry_t rdata;
  sepq_pkg::entry_t new_entry;
  logic [CW-1:0]    src;
  logic             match;

  assign is_insert = (req_q.command == sepq_pkg::CMD_INSERT);
  assign mv_inc    = mv + 1'b1;
  assign mv_dec    = mv - 1'b1;
  assign src       = is_insert ? mv_dec : mv_inc;

  assign new_entry.ev_time = req_q.event_time;
  assign new_entry.ev_id   = req_q.event_id;
  assign new_entry.cust    = req_q.customer_id;

  always_comb begin
    raddr = cmd.move_rd ? src[AW-1:0] : idx[AW-1:0];
    we    = cmd.move_wr | cmd.put_wr;
    if (cmd.put_wr) begin
      waddr = idx[AW-1:0];
      wdata = new_entry;
    end else begin
      waddr = mv[AW-1:0];
      wdata = rdata;
    end
  end

  sepq_ram #(
    .WIDTH (sepq_pkg::ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // entry compare for the current request
  always_comb begin
    unique case (req_q.command)
      sepq_pkg::CMD_INSERT: begin
        // head is passed over unless strictly later
        if (idx == '0) begin
          match = (rdata.ev_time > req_q.event_time);
        end else begin
          match = (rdata.ev_time >= req_q.event_time);
        end
      end
      sepq_pkg::CMD_REMOVE_MIN: match = 1'b1;
      sepq_pkg::CMD_REMOVE_CUS: match = (rdata.cust == req_q.customer_id);
      default:                  match = 1'b0;
    endcase
  end

  assign stat.match     = match;
  assign stat.new_cmd   = req.command;
  assign stat.cur_cmd   = req_q.command;
  assign stat.full      = (count == CW'(QUEUE_DEPTH));
  assign stat.empty     = (count == '0);
  assign stat.scan_end  = (idx == count);
  assign stat.move_done = is_insert ? (mv == idx) : (mv_inc == count);
  assign stat.out_busy  = rsp_valid & rsp_stall;

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_q <= req;
    end
    if (cmd.scan_start) begin
      idx <= '0;
    end else if (cmd.scan_adv) begin
      idx <= idx + 1'b1;
    end
    if (cmd.hit) begin
      mv <= is_insert ? count : idx;
    end else if (cmd.move_wr) begin
      mv <= is_insert ? mv_dec : mv_inc;
    end
    if (cmd.load_req) begin
      res_id   <= '0;
      res_time <= '0;
    end else if (cmd.hit && req_q.command == sepq_pkg::CMD_REMOVE_MIN) begin
      res_id   <= rdata.ev_id;
      res_time <= rdata.ev_time;
    end
    if (cmd.set_status) begin
      res_status <= cmd.status_val;
    end else if (cmd.load_req) begin
      res_status <= sepq_pkg::STAT_OK;
    end
    if (cmd.out_load) begin
      rsp.out_event_id   <= res_id;
      rsp.out_event_time <= res_time;
      rsp.status         <= res_status;
      rsp.occupancy      <= 8'(count);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (cmd.cnt_inc) begin
        count <= count + 1'b1;
      end else if (cmd.cnt_dec) begin
        count <= count - 1'b1;
      end
      if (cmd.out_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- src/sepq_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sepq_ctrl
// Sequencer for scan, shift and write of one queue request.
// ----------------------------------------------------------------------------
module sepq_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  output sepq_pkg::dp_cmd_t  cmd,
  input  sepq_pkg::dp_stat_t stat
);

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_SCAN_RD  = 7'b0000010,
    S_SCAN_CHK = 7'b0000100,
    S_MOVE_CHK = 7'b0001000,
    S_MOVE_WR  = 7'b0010000,
    S_PUT      = 7'b0100000,
    S_DONE     = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;

  assign req_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.load_req = 1'b1;
          unique case (stat.new_cmd)
            sepq_pkg::CMD_INSERT: begin
              if (stat.full) begin
                cmd.set_status = 1'b1;
                cmd.status_val = sepq_pkg::STAT_FULL;
                state_next     = S_DONE;
              end else begin
                cmd.scan_start = 1'b1;
                state_next     = S_SCAN_RD;
              end
            end
            sepq_pkg::CMD_REMOVE_MIN, sepq_pkg::CMD_REMOVE_CUS: begin
              if (stat.empty) begin
                cmd.set_status = 1'b1;
                cmd.status_val = sepq_pkg::STAT_EMPTY;
                state_next     = S_DONE;
              end else begin
                cmd.scan_start = 1'b1;
                state_next     = S_SCAN_RD;
              end
            end
            // unused code: nothing changes
            default: state_next = S_DONE;
          endcase
        end
      end
      S_SCAN_RD: begin
        if (stat.scan_end) begin
          if (stat.cur_cmd == sepq_pkg::CMD_INSERT) begin
            // append at the tail
            cmd.hit    = 1'b1;
            state_next = S_MOVE_CHK;
          end else begin
            cmd.set_status = 1'b1;
            cmd.status_val = sepq_pkg::STAT_NOT_FOUND;
            state_next     = S_DONE;
          end
        end else begin
          state_next = S_SCAN_CHK;
        end
      end
      S_SCAN_CHK: begin
        if (stat.match) begin
          cmd.hit    = 1'b1;
          state_next = S_MOVE_CHK;
        end else begin
          cmd.scan_adv = 1'b1;
          state_next   = S_SCAN_RD;
        end
      end
      S_MOVE_CHK: begin
        if (stat.move_done) begin
          if (stat.cur_cmd == sepq_pkg::CMD_INSERT) begin
            state_next = S_PUT;
          end else begin
            cmd.cnt_dec = 1'b1;
            state_next  = S_DONE;
          end
        end else begin
          cmd.move_rd = 1'b1;
          state_next  = S_MOVE_WR;
        end
      end
      S_MOVE_WR: begin
        cmd.move_wr = 1'b1;
        state_next  = S_MOVE_CHK;
      end
      S_PUT: begin
        cmd.put_wr  = 1'b1;
        cmd.cnt_inc = 1'b1;
        state_next  = S_DONE;
      end
      S_DONE: begin
        if (!stat.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ----- src/sorted_event_priority_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_event_priority_queue
// Bounded queue of timed events kept sorted by time in one entry RAM.
// ----------------------------------------------------------------------------
// One request at a time. The entries live in a single-port-write, registered
// read RAM, so every slot visited takes a read and a compare during the scan,
// and a read and a write during the shift that opens or closes the gap. A
// refused request (full, empty) or the unused command 3 goes straight to the
// result. The result sits in an output register, so a new request is taken
// while the last result waits; a result still held by stall keeps the next
// one waiting in the done state until the stall lifts.
// The RAM needs no clearing after reset: only entries below the count are used.
// ----------------------------------------------------------------------------
module sorted_event_priority_queue #(
  parameter int QUEUE_DEPTH = 128
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  sepq_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output sepq_pkg::rsp_t rsp
);

  sepq_pkg::dp_cmd_t  cmd;
  sepq_pkg::dp_stat_t stat;

  sepq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .cmd       (cmd),
    .stat      (stat)
  );

  sepq_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .rsp_stall (rsp_stall),
    .rsp_valid (rsp_valid),
    .rsp       (rsp),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule
